>>> rtl/lratree_pkg.sv
`default_nettype none
package lratree_pkg;

    localparam int LEAVES    = 1024;
    localparam int LEAF_LOG  = 10;
    localparam int NODE_W    = LEAF_LOG + 1;
    localparam int NODES     = 2 * LEAVES;
    localparam int STACK_D   = LEAF_LOG;
    localparam int SP_W      = 4;

    typedef struct packed {
        logic               op;
        logic [10:0]        range_lo;
        logic [10:0]        range_hi;
        logic signed [15:0] delta;
    } req_t;

    typedef struct packed {
        logic signed [31:0] max_value;
        logic [10:0]        max_pos;
        logic               status;
    } rsp_t;

endpackage
`default_nettype wire

>>> rtl/lazy_range_add_max_tree_top.sv
// Lazy segment tree over positions 1 to 1024 with range add and range maximum.
// Requests arrive on req/req_valid/req_stall and each request yields exactly one
// response on rsp/rsp_valid/rsp_stall. A transaction completes at a rising edge
// where valid is high and stall is low. Op 0 adds delta over [range_lo, range_hi];
// op 1 returns the maximum over that range and the position that holds it.
// One request is processed at a time by a sequencer that walks the tree with
// an explicit frame stack. Node maxima and pending adds sit in two single-port
// memories, so every node update is a read followed by a write-back. A lazy
// push moves a node's pending add into both children, and a query also searches
// below each fully covered node for the leaf that holds its maximum, so the tree
// walk sets the latency. The sequencer returns to idle as it loads the response
// register, and the next request can be accepted in the following cycle.
// After reset both memories are cleared in a pass over every node address,
// during which req_stall is high. A finished response is held in an output
// register, so a new request is taken while rsp_stall holds the previous
// response; the sequencer then waits at its end until that register is free
// again.
`default_nettype none
module lazy_range_add_max_tree_top import lratree_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam logic [NODE_W-1:0] SPAN = NODE_W'(LEAVES);
    localparam logic [NODE_W-1:0] ONE  = NODE_W'(1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DONE, S_VISIT, S_SPLIT, S_RET,
        S_RC0, S_RC1, S_RC2, S_FA0, S_FA1, S_FQ0, S_FQ1,
        S_LL, S_LL1, S_LL2, S_LL3, S_LL4,
        S_PD0, S_PD1, S_PD2, S_PD3, S_PD4, S_PD5, S_PD6, S_PD7
    } state_t;

    typedef enum logic [1:0] {
        PH_ONE, PH_LEFT, PH_RIGHT
    } phase_t;

    typedef struct packed {
        logic [NODE_W-1:0] v;
        logic [NODE_W-1:0] nl;
        logic [NODE_W-1:0] nr;
        logic [NODE_W-1:0] lo;
        logic [NODE_W-1:0] hi;
        phase_t            phase;
        logic [31:0]       lv;
        logic [NODE_W-1:0] lp;
    } frame_t;

    logic [31:0] nm_mem [NODES];
    logic [31:0] pd_mem [LEAVES];

    logic              nm_re, nm_we, pd_re, pd_we;
    logic [NODE_W-1:0] nm_addr;
    logic [LEAF_LOG-1:0] pd_addr;
    logic [31:0]       nm_wdata, pd_wdata, nm_q, pd_q;

    frame_t stack_reg [STACK_D];
    logic              push_en;
    logic [SP_W-1:0]   push_idx;
    frame_t            push_frame;

    state_t            state_reg, state_next, pd_ret_reg, pd_ret_next;
    frame_t            cur_reg, cur_next, pop_frame;
    logic [SP_W-1:0]   sp_reg, sp_next, sp_m1;
    logic              op_reg, op_next, bad_reg, bad_next;
    logic [31:0]       d_reg, d_next, ret_val_reg, ret_val_next;
    logic [NODE_W-1:0] ret_pos_reg, ret_pos_next;
    logic [31:0]       x_reg, x_next, a_reg, a_next, t_reg, t_next;
    logic [NODE_W-1:0] w_reg, w_next, pv_reg, pv_next, clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic [NODE_W:0]   cur_sum, pop_sum;
    logic [NODE_W-1:0] cur_mid, pop_mid, cur_v2, pop_v2, w2, pv2;

    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            nm_mem[nm_addr] <= nm_wdata;
        end
        if (nm_re)
        begin
            nm_q <= nm_mem[nm_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pd_we)
        begin
            pd_mem[pd_addr] <= pd_wdata;
        end
        if (pd_re)
        begin
            pd_q <= pd_mem[pd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_reg[push_idx] <= push_frame;
        end
    end

    assign sp_m1     = sp_reg - SP_W'(1);
    assign pop_frame = stack_reg[sp_m1];
    assign cur_sum   = {1'b0, cur_reg.nl} + {1'b0, cur_reg.nr};
    assign cur_mid   = cur_sum[NODE_W:1];
    assign pop_sum   = {1'b0, pop_frame.nl} + {1'b0, pop_frame.nr};
    assign pop_mid   = pop_sum[NODE_W:1];
    assign cur_v2    = {cur_reg.v[NODE_W-2:0], 1'b0};
    assign pop_v2    = {pop_frame.v[NODE_W-2:0], 1'b0};
    assign w2        = {w_reg[NODE_W-2:0], 1'b0};
    assign pv2       = {pv_reg[NODE_W-2:0], 1'b0};

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        pd_ret_next    = pd_ret_reg;
        cur_next       = cur_reg;
        sp_next        = sp_reg;
        op_next        = op_reg;
        bad_next       = bad_reg;
        d_next         = d_reg;
        ret_val_next   = ret_val_reg;
        ret_pos_next   = ret_pos_reg;
        x_next         = x_reg;
        a_next         = a_reg;
        t_next         = t_reg;
        w_next         = w_reg;
        pv_next        = pv_reg;
        clr_next       = clr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        nm_re = 1'b0; nm_we = 1'b0; nm_addr = '0; nm_wdata = '0;
        pd_re = 1'b0; pd_we = 1'b0; pd_addr = '0; pd_wdata = '0;
        push_en    = 1'b0;
        push_idx   = sp_reg;
        push_frame = cur_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                nm_we    = 1'b1;
                nm_addr  = clr_reg;
                pd_we    = 1'b1;
                pd_addr  = clr_reg[LEAF_LOG-1:0];
                clr_next = clr_reg + ONE;
                if (clr_reg == NODE_W'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.op;
                    d_next       = {{16{req.delta[15]}}, req.delta};
                    cur_next.v   = ONE;
                    cur_next.nl  = ONE;
                    cur_next.nr  = SPAN;
                    cur_next.lo  = req.range_lo;
                    cur_next.hi  = req.range_hi;
                    sp_next      = '0;
                    ret_val_next = '0;
                    ret_pos_next = '0;
                    if (req.range_lo == '0 || req.range_hi > SPAN
                        || req.range_lo > req.range_hi)
                    begin
                        bad_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = S_VISIT;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.status = bad_reg;
                    if (bad_reg || !op_reg)
                    begin
                        out_next.max_value = '0;
                        out_next.max_pos   = '0;
                    end
                    else
                    begin
                        out_next.max_value = ret_val_reg;
                        out_next.max_pos   = ret_pos_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_VISIT:
            begin
                if (cur_reg.nl == cur_reg.lo && cur_reg.nr == cur_reg.hi)
                begin
                    state_next = op_reg ? S_FQ0 : S_FA0;
                end
                else
                begin
                    pv_next     = cur_reg.v;
                    pd_ret_next = S_SPLIT;
                    state_next  = S_PD0;
                end
            end
            S_SPLIT:
            begin
                push_en = 1'b1;
                sp_next = sp_reg + SP_W'(1);
                if (cur_reg.hi <= cur_mid)
                begin
                    push_frame.phase = PH_ONE;
                    cur_next.v  = cur_v2;
                    cur_next.nr = cur_mid;
                end
                else if (cur_mid < cur_reg.lo)
                begin
                    push_frame.phase = PH_ONE;
                    cur_next.v  = cur_v2 | ONE;
                    cur_next.nl = cur_mid + ONE;
                end
                else
                begin
                    push_frame.phase = PH_LEFT;
                    cur_next.v  = cur_v2;
                    cur_next.nr = cur_mid;
                    cur_next.hi = cur_mid;
                end
                state_next = S_VISIT;
            end
            S_RET:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    sp_next  = sp_m1;
                    cur_next = pop_frame;
                    unique case (pop_frame.phase)
                        PH_LEFT:
                        begin
                            push_en          = 1'b1;
                            push_idx         = sp_m1;
                            push_frame       = pop_frame;
                            push_frame.phase = PH_RIGHT;
                            push_frame.lv    = ret_val_reg;
                            push_frame.lp    = ret_pos_reg;
                            sp_next          = sp_reg;
                            cur_next.v       = pop_v2 | ONE;
                            cur_next.nl      = pop_mid + ONE;
                            cur_next.lo      = pop_mid + ONE;
                            state_next       = S_VISIT;
                        end
                        PH_RIGHT:
                        begin
                            if (op_reg && ($signed(pop_frame.lv) > $signed(ret_val_reg)))
                            begin
                                ret_val_next = pop_frame.lv;
                                ret_pos_next = pop_frame.lp;
                            end
                            state_next = op_reg ? S_RET : S_RC0;
                        end
                        default:
                        begin
                            state_next = op_reg ? S_RET : S_RC0;
                        end
                    endcase
                end
            end
            S_RC0:
            begin
                nm_re      = 1'b1;
                nm_addr    = cur_v2;
                state_next = S_RC1;
            end
            S_RC1:
            begin
                a_next     = nm_q;
                nm_re      = 1'b1;
                nm_addr    = cur_v2 | ONE;
                state_next = S_RC2;
            end
            S_RC2:
            begin
                nm_we      = 1'b1;
                nm_addr    = cur_reg.v;
                nm_wdata   = ($signed(a_reg) > $signed(nm_q)) ? a_reg : nm_q;
                state_next = S_RET;
            end
            S_FA0:
            begin
                nm_re   = 1'b1;
                nm_addr = cur_reg.v;
                pd_re   = (cur_reg.v < SPAN);
                pd_addr = cur_reg.v[LEAF_LOG-1:0];
                state_next = S_FA1;
            end
            S_FA1:
            begin
                nm_we    = 1'b1;
                nm_addr  = cur_reg.v;
                nm_wdata = nm_q + d_reg;
                pd_we    = (cur_reg.v < SPAN);
                pd_addr  = cur_reg.v[LEAF_LOG-1:0];
                pd_wdata = pd_q + d_reg;
                state_next = S_RET;
            end
            S_FQ0:
            begin
                nm_re      = 1'b1;
                nm_addr    = cur_reg.v;
                state_next = S_FQ1;
            end
            S_FQ1:
            begin
                ret_val_next = nm_q;
                x_next       = nm_q;
                w_next       = cur_reg.v;
                state_next   = S_LL;
            end
            S_LL:
            begin
                if (w_reg >= SPAN)
                begin
                    ret_pos_next = (w_reg - SPAN) + ONE;
                    state_next   = S_RET;
                end
                else
                begin
                    pv_next     = w_reg;
                    pd_ret_next = S_LL1;
                    state_next  = S_PD0;
                end
            end
            S_LL1:
            begin
                pv_next     = w2;
                pd_ret_next = S_LL2;
                state_next  = S_PD0;
            end
            S_LL2:
            begin
                nm_re      = 1'b1;
                nm_addr    = w2;
                state_next = S_LL3;
            end
            S_LL3:
            begin
                if (nm_q == x_reg)
                begin
                    w_next     = w2;
                    state_next = S_LL;
                end
                else
                begin
                    pv_next     = w2 | ONE;
                    pd_ret_next = S_LL4;
                    state_next  = S_PD0;
                end
            end
            S_LL4:
            begin
                w_next     = w2 | ONE;
                state_next = S_LL;
            end
            S_PD0:
            begin
                if (pv_reg >= SPAN)
                begin
                    state_next = pd_ret_reg;
                end
                else
                begin
                    pd_re      = 1'b1;
                    pd_addr    = pv_reg[LEAF_LOG-1:0];
                    state_next = S_PD1;
                end
            end
            S_PD1:
            begin
                t_next     = pd_q;
                pd_we      = 1'b1;
                pd_addr    = pv_reg[LEAF_LOG-1:0];
                nm_re      = 1'b1;
                nm_addr    = pv2;
                state_next = S_PD2;
            end
            S_PD2:
            begin
                nm_we      = 1'b1;
                nm_addr    = pv2;
                nm_wdata   = nm_q + t_reg;
                state_next = S_PD3;
            end
            S_PD3:
            begin
                nm_re      = 1'b1;
                nm_addr    = pv2 | ONE;
                state_next = S_PD4;
            end
            S_PD4:
            begin
                nm_we    = 1'b1;
                nm_addr  = pv2 | ONE;
                nm_wdata = nm_q + t_reg;
                if (pv2 < SPAN)
                begin
                    pd_re      = 1'b1;
                    pd_addr    = pv2[LEAF_LOG-1:0];
                    state_next = S_PD5;
                end
                else
                begin
                    state_next = pd_ret_reg;
                end
            end
            S_PD5:
            begin
                pd_we      = 1'b1;
                pd_addr    = pv2[LEAF_LOG-1:0];
                pd_wdata   = pd_q + t_reg;
                state_next = S_PD6;
            end
            S_PD6:
            begin
                pd_re      = 1'b1;
                pd_addr    = pv2[LEAF_LOG-1:0] | LEAF_LOG'(1);
                state_next = S_PD7;
            end
            S_PD7:
            begin
                pd_we      = 1'b1;
                pd_addr    = pv2[LEAF_LOG-1:0] | LEAF_LOG'(1);
                pd_wdata   = pd_q + t_reg;
                state_next = pd_ret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pd_ret_reg    <= S_IDLE;
            cur_reg       <= '0;
            sp_reg        <= '0;
            op_reg        <= 1'b0;
            bad_reg       <= 1'b0;
            d_reg         <= '0;
            ret_val_reg   <= '0;
            ret_pos_reg   <= '0;
            x_reg         <= '0;
            a_reg         <= '0;
            t_reg         <= '0;
            w_reg         <= '0;
            pv_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pd_ret_reg    <= pd_ret_next;
            cur_reg       <= cur_next;
            sp_reg        <= sp_next;
            op_reg        <= op_next;
            bad_reg       <= bad_next;
            d_reg         <= d_next;
            ret_val_reg   <= ret_val_next;
            ret_pos_reg   <= ret_pos_next;
            x_reg         <= x_next;
            a_reg         <= a_next;
            t_reg         <= t_next;
            w_reg         <= w_next;
            pv_reg        <= pv_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_D))
        else $error("Frame stack depth exceeded.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> req_stall)
        else $error("Request taken during the clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (rsp.max_value == '0 && rsp.max_pos == '0))
        else $error("Rejected transaction carries a nonzero result.");

endmodule
`default_nettype wire
